// ===== design/msegt_pkg.sv =====
// Shared constants for the max segment tree block.
package msegt_pkg;

  localparam int LEAVES_DEF     = 1024;
  localparam int VALUE_BITS_DEF = 48;
  localparam int NODE_W_DEF     = $clog2(LEAVES_DEF) + 1;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

endpackage

// ===== design/max_segment_tree_unit.sv =====
// Top level of the range-max segment tree with point updates.
//
// Input channel (in_valid/in_ready): one item per request. in_req_type 0
// raises every node on the path from leaf in_position up to a child of
// the root to at least in_value and gives no result. in_req_type 1 asks
// for the maximum over leaves in_range_low..in_range_high (high bound
// saturates at LEAVES-2); the answer leaves on the result channel
// (out_valid/out_ready) as out_range_max, with out_is_empty set when
// nothing was stored there. The tree is walked one level per cycle
// through one dual-read memory and one shared max unit. A query stops
// climbing as soon as the cursors meet. in_ready is high only while idle.
// Reset: a clearing pass writes the most negative value into all
// 2*LEAVES nodes, one per cycle; in_ready stays low until it ends. A
// finished result sits in an output register: the next item is taken
// while it waits, and a later query holds in its final step until the
// receiver has taken the earlier result.
module max_segment_tree_unit #(
  parameter int LEAVES     = msegt_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = msegt_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [$clog2(LEAVES)-1:0]    in_position,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [$clog2(LEAVES)-1:0]    in_range_low,
  input  logic [$clog2(LEAVES)-1:0]    in_range_high,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_range_max,
  output logic                         out_is_empty
);
  import msegt_pkg::*;

  localparam int LOG_L  = $clog2(LEAVES);
  localparam int NODE_W = LOG_L + 1;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_QFIN  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [NODE_W-1:0]            clr_r, clr_nxt;
  logic [NODE_W-1:0]            node_a_r, node_a_nxt;   // update node / low cursor
  logic [NODE_W-1:0]            node_b_r, node_b_nxt;   // high cursor
  logic [NODE_W-1:0]            wr_addr_r, wr_addr_nxt;
  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic signed [VALUE_BITS-1:0] best_r, best_nxt;
  logic                         is_qry_r, is_qry_nxt;
  logic                         pend_a_r, pend_a_nxt;   // read data valid next cycle
  logic                         pend_b_r, pend_b_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0] out_max_r, out_max_nxt;
  logic                         out_empty_r, out_empty_nxt;

  logic                         in_fire;
  logic                         cursors_open;
  logic [LOG_L-1:0]             hi_sat;
  logic                         mem_we;
  logic [NODE_W-1:0]            mem_waddr;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic [NODE_W-1:0]            rd_addr_a, rd_addr_b;
  logic signed [VALUE_BITS-1:0] rd_data_a, rd_data_b;
  logic signed [VALUE_BITS-1:0] max_base, max_out;

  assign in_ready      = (state_r == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;
  assign out_is_empty  = out_empty_r;

  // Keep the upper cursor inside the tree.
  assign hi_sat = (in_range_high > LOG_L'(LEAVES - 2)) ? LOG_L'(LEAVES - 2) : in_range_high;

  // Open-interval cursors still enclose a node.
  assign cursors_open = (({1'b0, node_a_r} + (NODE_W+1)'(1)) < {1'b0, node_b_r});

  // Update reads the path node itself; query reads the nodes inside the cursors.
  assign rd_addr_a = is_qry_r ? (node_a_r + NODE_W'(1)) : node_a_r;
  assign rd_addr_b = node_b_r - NODE_W'(1);

  // Clearing pass owns the write port until it ends.
  assign mem_we    = (state_r == S_CLEAR) || (pend_a_r && !is_qry_r);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : wr_addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? VAL_MIN : max_out;

  assign max_base = is_qry_r ? best_r : val_r;

  msegt_mem #(
    .ADDR_W (NODE_W),
    .DATA_W (VALUE_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  msegt_max #(
    .DATA_W (VALUE_BITS)
  ) u_max (
    .base   (max_base),
    .cand_a (rd_data_a),
    .en_a   (pend_a_r),
    .cand_b (rd_data_b),
    .en_b   (pend_b_r),
    .result (max_out)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_a_nxt    = node_a_r;
    node_b_nxt    = node_b_r;
    wr_addr_nxt   = wr_addr_r;
    val_nxt       = val_r;
    is_qry_nxt    = is_qry_r;
    pend_a_nxt    = 1'b0;
    pend_b_nxt    = 1'b0;
    best_nxt      = is_qry_r ? max_out : best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_max_nxt   = out_max_r;
    out_empty_nxt = out_empty_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + NODE_W'(1);
        if (clr_r == {NODE_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          is_qry_nxt = (in_req_type == REQ_QUERY);
          val_nxt    = in_value;
          best_nxt   = VAL_MIN;
          node_b_nxt = {1'b0, hi_sat} + NODE_W'(LEAVES + 1);
          if (in_req_type == REQ_QUERY) begin
            node_a_nxt = {1'b0, in_range_low} + NODE_W'(LEAVES - 1);
            state_nxt  = S_QRY;
          end else begin
            node_a_nxt = {1'b0, in_position} + NODE_W'(LEAVES);
            state_nxt  = S_UPD;
          end
        end
      end
      S_UPD: begin
        // Read this level; the merge and write-back follow in the next cycle.
        pend_a_nxt  = 1'b1;
        wr_addr_nxt = node_a_r;
        node_a_nxt  = node_a_r >> 1;
        if ((node_a_r >> 1) == NODE_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_QRY: begin
        pend_a_nxt = cursors_open && !node_a_r[0];
        pend_b_nxt = cursors_open && node_b_r[0];
        node_a_nxt = node_a_r >> 1;
        node_b_nxt = node_b_r >> 1;
        if (!cursors_open) begin
          state_nxt = S_QFIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_QFIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_r;
          out_empty_nxt = (best_r == VAL_MIN);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_a_r    <= 1'b0;
      pend_b_r    <= 1'b0;
      is_qry_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_a_r    <= pend_a_nxt;
      pend_b_r    <= pend_b_nxt;
      is_qry_r    <= is_qry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_a_r    <= node_a_nxt;
    node_b_r    <= node_b_nxt;
    wr_addr_r   <= wr_addr_nxt;
    val_r       <= val_nxt;
    best_r      <= best_nxt;
    out_max_r   <= out_max_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

// ===== design/msegt_mem.sv =====
// Tree node storage: one write port, two registered read ports.
module msegt_mem #(
  parameter int ADDR_W = msegt_pkg::NODE_W_DEF,
  parameter int DATA_W = msegt_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr_a,
  input  logic [ADDR_W-1:0]        raddr_b,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b
);
  import msegt_pkg::*;

  logic signed [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/msegt_max.sv =====
// Shared max unit: merges up to two enabled candidates into a running value.
module msegt_max #(
  parameter int DATA_W = msegt_pkg::VALUE_BITS_DEF
) (
  input  logic signed [DATA_W-1:0] base,
  input  logic signed [DATA_W-1:0] cand_a,
  input  logic                     en_a,
  input  logic signed [DATA_W-1:0] cand_b,
  input  logic                     en_b,
  output logic signed [DATA_W-1:0] result
);
  import msegt_pkg::*;

  logic signed [DATA_W-1:0] step_a;

  always_comb begin
    step_a = (en_a && (cand_a > base)) ? cand_a : base;
    result = (en_b && (cand_b > step_a)) ? cand_b : step_a;
  end

endmodule

// ===== design/msegt_chk.sv =====
// Port-level checker for the max segment tree block, bound to the top level.
module msegt_chk #(
  parameter int LEAVES     = msegt_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = msegt_pkg::VALUE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_range_max,
  input logic                         out_is_empty
);
  import msegt_pkg::*;

  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Held result stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_max) && $stable(out_is_empty))
    else $error("result changed while stalled");

  // Empty flag agrees with the sentinel value.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_range_max == VAL_MIN)))
    else $error("empty flag disagrees with range max");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Block stays busy while reset is applied (clearing pass follows).
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during clearing pass");

endmodule

bind max_segment_tree_unit msegt_chk #(
  .LEAVES     (LEAVES),
  .VALUE_BITS (VALUE_BITS)
) u_msegt_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_range_max (out_range_max),
  .out_is_empty  (out_is_empty)
);
